FILE: rtl/sqs_pkg.sv
// shared types and constants for the shift queue with search
package sqs_pkg;

    localparam int MODE_W = 2;
    localparam int KEY_W  = 32;
    localparam int POS_W  = 4;
    localparam int OCC_W  = 5;

    typedef enum logic [MODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic             cmp;
        logic             scan;
        logic [KEY_W-1:0] key;
    } cell_ctl_t;

endpackage

FILE: rtl/sqs_if.sv
// valid/ready channel interfaces for requests and responses
interface sqs_req_if;
    logic                             valid;
    logic                             ready;
    logic [sqs_pkg::MODE_W-1:0]       mode;
    logic signed [sqs_pkg::KEY_W-1:0] key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

interface sqs_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      success;
    logic [sqs_pkg::POS_W-1:0] position;
    logic [sqs_pkg::OCC_W-1:0] occupancy;

    modport source (output valid, output success, output position, output occupancy,
                    input ready);
    modport sink   (input valid, input success, input position, input occupancy,
                    output ready);
endinterface

FILE: rtl/sqs_cell.sv
// one queue cell: a stored key plus a match flag, both shifting toward the head
module sqs_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sqs_pkg::cell_ctl_t            ctl,
    input  logic [CNT_W-1:0]              count,
    input  logic [sqs_pkg::KEY_W-1:0]     next_entry,
    input  logic                          next_flag,
    output logic [sqs_pkg::KEY_W-1:0]     entry,
    output logic                          flag
);

    logic [sqs_pkg::KEY_W-1:0] entry_reg;
    logic                      flag_reg;
    logic                      occupied;

    assign occupied = CNT_W'(INDEX) < count;

    always_ff @(posedge clk)
    begin
        if (ctl.ins && (count == CNT_W'(INDEX)))
        begin
            entry_reg <= ctl.key;
        end
        else if (ctl.rem)
        begin
            entry_reg <= next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else if (ctl.cmp)
        begin
            flag_reg <= occupied && (entry_reg == ctl.key);
        end
        else if (ctl.scan)
        begin
            flag_reg <= next_flag;
        end
    end

    assign entry = entry_reg;
    assign flag  = flag_reg;

endmodule

FILE: rtl/sqs_ctrl.sv
// sequencer: count, search scan, response register and handshakes
module sqs_ctrl #(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sqs_req_if.sink              req,
    sqs_rsp_if.source            rsp,
    input  logic                 head_flag,
    output sqs_pkg::cell_ctl_t   ctl,
    output logic [CNT_W-1:0]     count
);

    sqs_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;

    logic                      rsp_valid_reg, rsp_valid_next;
    logic                      success_reg, success_next;
    logic [sqs_pkg::POS_W-1:0] position_reg, position_next;
    logic [sqs_pkg::OCC_W-1:0] occupancy_reg, occupancy_next;

    logic slot_free;
    logic fire;
    logic full;
    logic empty;
    logic scan_last;
    logic scan_done;
    sqs_pkg::op_t op;

    assign op        = sqs_pkg::op_t'(req.mode);
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == sqs_pkg::ST_IDLE) && slot_free;
    assign fire      = req.valid && req.ready;
    assign full      = count_reg == CNT_W'(DEPTH);
    assign empty     = count_reg == '0;
    assign scan_last = ({1'b0, scan_reg} + (CNT_W+1)'(1)) >= {1'b0, count_reg};
    assign scan_done = head_flag || scan_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sqs_pkg::ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        success_reg   <= success_next;
        position_reg  <= position_next;
        occupancy_reg <= occupancy_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        success_next   = success_reg;
        position_next  = position_reg;
        occupancy_next = occupancy_reg;
        ctl            = '0;
        ctl.key        = req.key;

        unique case (state_reg)
            sqs_pkg::ST_IDLE:
            begin
                if (fire)
                begin
                    case (op)
                        sqs_pkg::OP_INSERT:
                        begin
                            ctl.ins        = !full;
                            count_next     = full ? count_reg : count_reg + CNT_W'(1);
                            rsp_valid_next = 1'b1;
                            success_next   = !full;
                            position_next  = '0;
                        end
                        sqs_pkg::OP_REMOVE:
                        begin
                            ctl.rem        = !empty;
                            count_next     = empty ? count_reg : count_reg - CNT_W'(1);
                            rsp_valid_next = 1'b1;
                            success_next   = !empty;
                            position_next  = '0;
                        end
                        sqs_pkg::OP_SEARCH:
                        begin
                            ctl.cmp    = 1'b1;
                            scan_next  = '0;
                            state_next = sqs_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                            success_next   = 1'b0;
                            position_next  = '0;
                        end
                    endcase
                    occupancy_next = sqs_pkg::OCC_W'(32'(count_next));
                end
            end
            sqs_pkg::ST_SCAN:
            begin
                if (!scan_done)
                begin
                    ctl.scan  = 1'b1;
                    scan_next = scan_reg + CNT_W'(1);
                end
                else if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    success_next   = head_flag;
                    position_next  = head_flag ? sqs_pkg::POS_W'(32'(scan_reg)) : '0;
                    occupancy_next = sqs_pkg::OCC_W'(32'(count_reg));
                    state_next     = sqs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sqs_pkg::ST_IDLE;
            end
        endcase
    end

    assign count         = count_reg;
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.success   = success_reg;
    assign rsp.position  = position_reg;
    assign rsp.occupancy = occupancy_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |-> !req.ready)
        else $error("request taken while response stalled");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && op == sqs_pkg::OP_INSERT && !full) |=>
            (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance count");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sqs_pkg::ST_SCAN) |-> (scan_reg < count_reg || scan_reg == '0))
        else $error("scan ran past occupied cells");

    a_scan_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sqs_pkg::ST_SCAN) |=> $stable(count_reg))
        else $error("count changed during search");
`endif

endmodule

FILE: rtl/shift_queue_with_search.sv
// top level: shift-register queue of signed keys with linear search
//
//  channel | dir | payload                          | handshake
//  --------+-----+----------------------------------+------------------
//  req     | in  | mode[1:0], key[31:0] signed      | valid / ready
//  rsp     | out | success, position[3:0], occ[4:0] | valid / ready
//
// insert and remove load the response register at the same edge the transaction
// is taken, so one can follow the next back to back while each response is taken.
// search compares every cell at the edge the request is taken, then shifts the
// match flags one cell per cycle toward the head until a hit reaches the head or
// the scan reaches the last occupied cell; the response then waits for a free slot.
// rst_n clears count, control and match flags; stored keys are not reset.
// a stalled response holds req.ready low until it is taken
module shift_queue_with_search #(
    parameter int DEPTH = 16
) (
    input logic       clk,
    input logic       rst_n,
    sqs_req_if.sink   req,
    sqs_rsp_if.source rsp
);

    // count must reach DEPTH itself
    localparam int CNT_W = $clog2(DEPTH + 1);

    sqs_pkg::cell_ctl_t ctl;
    logic [CNT_W-1:0]   count;

    // entry and flag outputs of each cell, plus the fill value past the tail
    logic [sqs_pkg::KEY_W-1:0] entries [DEPTH+1];
    logic [DEPTH:0]            flags;

    assign entries[DEPTH] = '0;
    assign flags[DEPTH]   = 1'b0;

    // sequencer owns the handshakes, count and response register
    sqs_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .head_flag (flags[0]),
        .ctl       (ctl),
        .count     (count)
    );

    // cell 0 is the head; every cell takes its neighbor's key on remove
    // and its neighbor's match flag on each scan step
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sqs_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .count      (count),
            .next_entry (entries[i+1]),
            .next_flag  (flags[i+1]),
            .entry      (entries[i]),
            .flag       (flags[i])
        );
    end

endmodule

FILE: sim/sqs_queue_checker.sv
// checker for the shift queue: tracks queue contents and compares every response
`timescale 1ns / 1ps

module sqs_queue_checker #(
    parameter int DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    sqs_req_if   req,
    sqs_rsp_if   rsp,
    output int   mismatch_count,
    output int   awaiting,
    output int   results_seen,
    output int   search_hits,
    output int   inserts_refused,
    output int   removes_refused
);

    typedef struct packed {
        logic                      success;
        logic [sqs_pkg::POS_W-1:0] position;
        logic [sqs_pkg::OCC_W-1:0] occupancy;
    } queue_reply_t;

    logic signed [sqs_pkg::KEY_W-1:0] shadow_keys[$];
    queue_reply_t                     reply_fifo[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // applies one request to the shadow queue and returns the response it should give
    function automatic queue_reply_t apply_request(
        input logic [sqs_pkg::MODE_W-1:0]       mode,
        input logic signed [sqs_pkg::KEY_W-1:0] key);
        queue_reply_t reply;
        int           hit;
        reply = '0;
        hit   = -1;
        case (mode)
            sqs_pkg::OP_INSERT:
            begin
                if (shadow_keys.size() < DEPTH)
                begin
                    shadow_keys.push_back(key);
                    reply.success = 1'b1;
                end
                else
                    inserts_refused++;
            end
            sqs_pkg::OP_REMOVE:
            begin
                if (shadow_keys.size() > 0)
                begin
                    void'(shadow_keys.pop_front());
                    reply.success = 1'b1;
                end
                else
                    removes_refused++;
            end
            sqs_pkg::OP_SEARCH:
            begin
                // first match from the head, occupied cells only
                for (int i = 0; i < shadow_keys.size(); i++)
                    if (hit < 0 && shadow_keys[i] == key)
                        hit = i;
                if (hit >= 0)
                begin
                    reply.success  = 1'b1;
                    reply.position = sqs_pkg::POS_W'(hit);
                    search_hits++;
                end
            end
            default:
            begin
            end
        endcase
        reply.occupancy = sqs_pkg::OCC_W'(shadow_keys.size());
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        queue_reply_t want;
        if (!rst_n)
        begin
            shadow_keys.delete();
            reply_fifo.delete();
            awaiting        <= 0;
            mismatch_count  = 0;
            results_seen    = 0;
            search_hits     = 0;
            inserts_refused = 0;
            removes_refused = 0;
        end
        else
        begin
            // response first: it can never belong to a request taken at this same edge
            if (rsp.valid && rsp.ready)
            begin
                results_seen++;
                if (reply_fifo.size() == 0)
                    report_mismatch("response with nothing outstanding", rsp.occupancy, 0);
                else
                begin
                    want = reply_fifo.pop_front();
                    if (rsp.success !== want.success)
                        report_mismatch("success", rsp.success, want.success);
                    if (rsp.position !== want.position)
                        report_mismatch("position", rsp.position, want.position);
                    if (rsp.occupancy !== want.occupancy)
                        report_mismatch("occupancy", rsp.occupancy, want.occupancy);
                end
            end
            if (req.valid && req.ready)
                reply_fifo.push_back(apply_request(req.mode, req.key));
            awaiting <= reply_fifo.size();
        end
    end

endmodule

FILE: sim/tb_shift_queue_with_search.sv
// testbench top: clock, reset, request and response traffic, verdict
`timescale 1ns / 1ps

module tb_shift_queue_with_search;

    localparam int DEPTH       = 16;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 190;
    // longest quiet stretch in a correct run stays well below this limit
    localparam int QUIET_LIMIT = 1000;

    // mode value with no operation behind it
    localparam logic [sqs_pkg::MODE_W-1:0]       MODE_UNUSED = 2'd3;
    localparam logic signed [sqs_pkg::KEY_W-1:0] KEY_MIN     = 32'sh8000_0000;
    localparam logic signed [sqs_pkg::KEY_W-1:0] KEY_MAX     = 32'sh7fff_ffff;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } phase_kind_t;

    logic clk;
    logic rst_n;
    logic src_steady;
    logic sink_steady;
    int   quiet_cycles;
    int   stall_left;

    int mismatch_count;
    int awaiting;
    int results_seen;
    int search_hits;
    int inserts_refused;
    int removes_refused;

    // keys recently inserted, so searches mostly hit something
    logic signed [sqs_pkg::KEY_W-1:0] recent_keys[$];

    sqs_req_if req_ch ();
    sqs_rsp_if rsp_ch ();

    shift_queue_with_search #(
        .DEPTH (DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sqs_queue_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .mismatch_count  (mismatch_count),
        .awaiting        (awaiting),
        .results_seen    (results_seen),
        .search_hits     (search_hits),
        .inserts_refused (inserts_refused),
        .removes_refused (removes_refused)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // response side: mostly ready, short stalls, now and then a long one
    always @(posedge clk)
    begin
        int r;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (sink_steady)
            rsp_ch.ready <= 1'b1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                rsp_ch.ready <= 1'b1;
            else if (r < 95)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= $urandom_range(0, 2);
            end
            else
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= $urandom_range(8, 40);
            end
        end
    end

    // watchdog: cycles in which neither channel moves a transaction
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        quiet_cycles = 0;
        @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // present one request and hold it until the transaction completes
    task automatic send_op(input logic [sqs_pkg::MODE_W-1:0]       mode,
                           input logic signed [sqs_pkg::KEY_W-1:0] key);
        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.key   <= key;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (mode == sqs_pkg::OP_INSERT)
        begin
            recent_keys.push_back(key);
            if (recent_keys.size() > 24)
                void'(recent_keys.pop_front());
        end
    endtask

    task automatic pause_sender(input int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // sender holds off until every outstanding response is back
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaiting != 0);
    endtask

    // gap before the next request: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (src_steady || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // small values give duplicates, a few extremes, the rest full range
    function automatic logic signed [sqs_pkg::KEY_W-1:0] fresh_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return sqs_pkg::KEY_W'($urandom_range(0, 7)) - 32'sd4;
        else if (r < 35)
        begin
            case ($urandom_range(0, 3))
                0:       return KEY_MIN;
                1:       return KEY_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        else
            return $urandom;
    endfunction

    initial
    begin
        logic signed [sqs_pkg::KEY_W-1:0] key;
        logic signed [sqs_pkg::KEY_W-1:0] tail_key;
        logic [sqs_pkg::MODE_W-1:0]       mode;
        phase_kind_t                      kind;
        int                               ins_w;
        int                               rem_w;
        int                               r;
        int                               gap;

        // every input known from time zero, reset held before traffic starts
        rst_n        = 1'b0;
        src_steady   = 1'b0;
        sink_steady  = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode  = sqs_pkg::OP_INSERT;
        req_ch.key   = '0;
        rsp_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: refusals and no-ops on an empty queue
        send_op(sqs_pkg::OP_REMOVE, 32'sd5);
        send_op(sqs_pkg::OP_SEARCH, '0);
        send_op(MODE_UNUSED, KEY_MAX);

        // fill to the brim with the extreme keys, a duplicate and a known tail key
        tail_key = $urandom;
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i)
                0:         key = KEY_MIN;
                1:         key = KEY_MAX;
                2:         key = '0;
                3:         key = '1;
                4:         key = 32'sh5555_5555;
                5:         key = 32'shaaaa_aaaa;
                6:         key = KEY_MAX;
                DEPTH - 1: key = tail_key;
                default:   key = $urandom;
            endcase
            send_op(sqs_pkg::OP_INSERT, key);
            gap = pick_gap();
            if (gap > 0)
                pause_sender(gap);
        end

        // full queue: refused insert, last-cell hit, first of duplicates, miss, no-op, remove
        send_op(sqs_pkg::OP_INSERT, 32'sd1);
        send_op(sqs_pkg::OP_SEARCH, tail_key);
        send_op(sqs_pkg::OP_SEARCH, KEY_MAX);
        send_op(sqs_pkg::OP_SEARCH, 32'sh1234_5678);
        send_op(MODE_UNUSED, KEY_MIN);
        send_op(sqs_pkg::OP_REMOVE, '1);
        drain_responses();

        // random phases: fill, drain and mixed traffic with varying idle behavior
        for (int p = 0; p < PHASES; p++)
        begin
            kind        = phase_kind_t'(p % 3);
            src_steady  = (p % 4 == 1);
            sink_steady <= (p % 3 == 2);
            case (kind)
                PH_FILL:
                begin
                    ins_w = 55;
                    rem_w = 15;
                end
                PH_DRAIN:
                begin
                    ins_w = 15;
                    rem_w = 55;
                end
                default:
                begin
                    ins_w = 35;
                    rem_w = 30;
                end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r == 0)
                    mode = MODE_UNUSED;
                else if (r <= ins_w)
                    mode = sqs_pkg::OP_INSERT;
                else if (r <= ins_w + rem_w)
                    mode = sqs_pkg::OP_REMOVE;
                else
                    mode = sqs_pkg::OP_SEARCH;

                if (mode == sqs_pkg::OP_SEARCH && recent_keys.size() > 0
                    && $urandom_range(0, 99) < 65)
                    key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                else
                    key = fresh_key();

                send_op(mode, key);
                gap = pick_gap();
                if (gap > 0)
                    pause_sender(gap);
            end

            // let the queue settle between phases
            drain_responses();
        end

        // wait out the slowest search before judging
        drain_responses();
        repeat (DEPTH + 4) @(posedge clk);

        $display("checked %0d responses: %0d search hits, %0d inserts refused when full, "
                 , results_seen, search_hits, inserts_refused);
        $display("%0d removes refused when empty, across fill, drain and mixed traffic",
                 removes_refused);
        if (mismatch_count == 0 && awaiting == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
